>>> sv/tpm_spi_transaction_framer_assert.svh
// ----------------------------------------------------------------------------
// TPM SPI transaction framer assertion macros
// Concurrent assertion wrappers that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef TPM_SPI_TRANSACTION_FRAMER_ASSERT_SVH
`define TPM_SPI_TRANSACTION_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define TSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TSF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/tsf_pkg.sv
// ----------------------------------------------------------------------------
// TPM SPI transaction framer package
// Shared types, codes and constants of the framer.
// ----------------------------------------------------------------------------
package tsf_pkg;

	localparam int MAX_CHUNK = 64;
	localparam int CHUNK_W = $clog2(MAX_CHUNK + 1);

	localparam logic [7:0] READ_FLAG = 8'h80;
	localparam logic [7:0] LEN_MASK = 8'h3F;
	localparam logic [7:0] HDR_CMD = 8'hD4;
	localparam logic [7:0] WAIT_LIMIT_RST = 8'd100;

	localparam logic OP_START = 1'b0;
	localparam logic OP_XFER = 1'b1;

	localparam logic [1:0] ST_BUSY = 2'd0;
	localparam logic [1:0] ST_OK = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;
	localparam logic [1:0] ST_REJECT = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HEADER = 2'd1,
		PH_WAIT = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	typedef struct packed {
		logic opcode;
		logic read_not_write;
		logic [15:0] address;
		logic [15:0] length;
		logic [7:0] write_byte;
		logic [7:0] miso_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] mosi_byte;
		logic send_byte;
		logic frame_start;
		logic frame_end;
		logic [7:0] rx_byte;
		logic rx_valid;
		logic write_taken;
		logic done_res;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		phase_t phase;
		logic [CHUNK_W-1:0] idx;
		logic [15:0] remaining;
		logic [CHUNK_W-1:0] chunk;
		logic [15:0] address;
		logic reading;
		logic [7:0] wait_count;
	} state_t;

endpackage

>>> sv/tsf_chan_if.sv
// ----------------------------------------------------------------------------
// TPM SPI transaction framer channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface tsf_in_if;
	import tsf_pkg::*;

	logic valid;
	logic ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface tsf_out_if;
	import tsf_pkg::*;

	logic valid;
	logic ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

>>> sv/tsf_core.sv
// ----------------------------------------------------------------------------
// TPM SPI transaction framer core
// Transaction state and the single-pass step logic that forms each result.
// ----------------------------------------------------------------------------
`include "tpm_spi_transaction_framer_assert.svh"

module tsf_core (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  tsf_pkg::in_item_t item,
	input  logic [7:0] wait_limit,
	output tsf_pkg::out_item_t res
);
	import tsf_pkg::*;

	state_t st_q;
	state_t nxt;

	logic do_open;
	logic [15:0] open_rem;
	logic open_rd;
	logic go_data;
	logic go_wait;
	logic do_emit;
	logic [CHUNK_W-1:0] open_c;
	logic [CHUNK_W-1:0] lenm1;
	logic [15:0] sub;
	logic [15:0] rem_left;

	always_comb begin
		res = '0;
		nxt = st_q;
		do_open = 1'b0;
		open_rem = st_q.remaining;
		open_rd = st_q.reading;
		go_data = 1'b0;
		go_wait = 1'b0;
		do_emit = 1'b0;
		sub = (st_q.remaining < 16'(st_q.chunk)) ? st_q.remaining : 16'(st_q.chunk);
		rem_left = st_q.remaining - sub;

		if (item.opcode == OP_START) begin
			if (st_q.phase != PH_IDLE) begin
				res.status = ST_REJECT;
			end else begin
				nxt.reading = item.read_not_write;
				nxt.address = item.address;
				nxt.remaining = item.length;
				if (item.length == 16'd0) begin
					res.done_res = 1'b1;
					res.status = ST_OK;
				end else begin
					do_open = 1'b1;
					open_rem = item.length;
					open_rd = item.read_not_write;
				end
			end
		end else begin
			case (st_q.phase)
				PH_HEADER: begin
					if (st_q.idx == CHUNK_W'(1)) begin
						res.mosi_byte = HDR_CMD;
						res.send_byte = 1'b1;
						nxt.idx = CHUNK_W'(2);
					end else if (st_q.idx == CHUNK_W'(2)) begin
						res.mosi_byte = st_q.address[15:8];
						res.send_byte = 1'b1;
						nxt.idx = CHUNK_W'(3);
					end else if (st_q.idx == CHUNK_W'(3)) begin
						res.mosi_byte = st_q.address[7:0];
						res.send_byte = 1'b1;
						nxt.idx = CHUNK_W'(4);
					end else if (item.miso_byte[0]) begin
						go_data = 1'b1;
					end else begin
						go_wait = 1'b1;
					end
				end
				PH_WAIT: begin
					if (item.miso_byte[0]) begin
						go_data = 1'b1;
					end else begin
						go_wait = 1'b1;
					end
				end
				PH_DATA: begin
					if (st_q.reading) begin
						res.rx_byte = item.miso_byte;
						res.rx_valid = 1'b1;
					end
					if (st_q.idx >= st_q.chunk) begin
						res.frame_end = 1'b1;
						nxt.remaining = rem_left;
						if (rem_left == 16'd0) begin
							res.done_res = 1'b1;
							res.status = ST_OK;
							nxt.phase = PH_IDLE;
						end else begin
							do_open = 1'b1;
							open_rem = rem_left;
						end
					end else begin
						nxt.idx = st_q.idx + CHUNK_W'(1);
						do_emit = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		if (go_data) begin
			nxt.phase = PH_DATA;
			nxt.idx = CHUNK_W'(1);
			do_emit = 1'b1;
		end

		if (do_emit) begin
			res.send_byte = 1'b1;
			if (!st_q.reading) begin
				res.mosi_byte = item.write_byte;
				res.write_taken = 1'b1;
			end
		end

		if (go_wait) begin
			if (st_q.wait_count >= wait_limit) begin
				res.frame_end = 1'b1;
				res.done_res = 1'b1;
				res.status = ST_TIMEOUT;
				nxt.phase = PH_IDLE;
			end else begin
				nxt.wait_count = st_q.wait_count + 8'd1;
				res.send_byte = 1'b1;
				nxt.phase = PH_WAIT;
			end
		end

		open_c = (open_rem < 16'(MAX_CHUNK)) ? open_rem[CHUNK_W-1:0] : CHUNK_W'(MAX_CHUNK);
		lenm1 = open_c - CHUNK_W'(1);
		if (do_open) begin
			nxt.chunk = open_c;
			res.mosi_byte = (open_rd ? READ_FLAG : 8'h00) | (8'(lenm1) & LEN_MASK);
			res.send_byte = 1'b1;
			res.frame_start = 1'b1;
			nxt.idx = CHUNK_W'(1);
			nxt.wait_count = 8'd0;
			nxt.phase = PH_HEADER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, default: '0};
		end else if (step) begin
			st_q <= nxt;
		end
	end

	`TSF_ASSERT_IMPL(a_wait_counted, clk, arst_n, st_q.phase == PH_WAIT, st_q.wait_count != 8'd0)
	`TSF_ASSERT_IMPL(a_data_idx, clk, arst_n, st_q.phase == PH_DATA, (st_q.idx != '0) && (st_q.idx <= st_q.chunk))
	`TSF_ASSERT_IMPL(a_hdr_idx, clk, arst_n, st_q.phase == PH_HEADER, (st_q.idx != '0) && (st_q.idx <= CHUNK_W'(4)))
	`TSF_ASSERT_IMPL(a_chunk_set, clk, arst_n, st_q.phase != PH_IDLE, st_q.chunk != '0)

endmodule

>>> sv/tpm_spi_transaction_framer.sv
// ----------------------------------------------------------------------------
// TPM SPI transaction framer
// Host-side TPM SPI sequencer that frames transactions one byte at a time.
// ----------------------------------------------------------------------------
// Channel   Dir   Handshake             Carries
// req       in    req.valid/req.ready   start or exchanged-byte item
// rsp       out   rsp.valid/rsp.ready   next byte and status item
// cfg       in    cfg_we                wait limit
//
// Each item passes through the input register and then the result register
// before its result is offered. One item is taken per cycle while the result
// side is not stalled. The result register frees the input side, so a stalled
// result only holds one further item in the input register. Reset clears the
// control state and sets the wait limit to 100.
// ----------------------------------------------------------------------------
`include "tpm_spi_transaction_framer_assert.svh"

module tpm_spi_transaction_framer (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [7:0] cfg_wdata,
	tsf_in_if.sink req,
	tsf_out_if.source rsp
);
	import tsf_pkg::*;

	logic valid_s1;
	in_item_t item_s1;
	logic valid_s2;
	out_item_t res_s2;
	out_item_t res;
	logic [7:0] wait_limit_q;
	logic advance;

	assign advance = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = valid_s2;
	assign rsp.item = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			wait_limit_q <= WAIT_LIMIT_RST;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
			if (cfg_we) begin
				wait_limit_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.item;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	tsf_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.item(item_s1),
		.wait_limit(wait_limit_q),
		.res(res)
	);

	`TSF_ASSERT_NEXT(a_adv_fills, clk, arst_n, advance, valid_s2)
	`TSF_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(item_s1))
	`TSF_ASSERT_IMPL(a_full_stall, clk, arst_n, valid_s1 && valid_s2 && !rsp.ready, !req.ready)

endmodule
